[sv/uvs_pkg.sv]
// shared types, constants and tables of the uv sphere vertex generator
`default_nettype none

package uvs_pkg;

  localparam int IdxW     = 10;  // grid index and count width at the ports
  localparam int CfgW     = 16;  // widest configuration register
  localparam int CfgIdxW  = 2;
  localparam int RadW     = 16;
  localparam int PhaseW   = 32;  // 2^32 is one full turn
  localparam int QuotW    = 33;  // phase quotient, one more bit for a full turn
  localparam int CordW    = 34;  // cordic datapath, Q2.30 plus headroom
  localparam int PosW     = 17;
  localparam int TexW     = 17;
  localparam int VidxW    = 20;
  localparam int AtanLen  = 24;

  localparam int DivSteps         = 32;
  localparam int DivStepsPerStage = 4;
  localparam int DivStages        = DivSteps / DivStepsPerStage;

  localparam logic [CordW-1:0] CORDIC_START = 34'h026DD3B6A;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEGMENT_COUNT = 2'd0,
    CFG_RING_COUNT    = 2'd1,
    CFG_SPHERE_RADIUS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [IdxW-1:0] segs;
    logic [IdxW-1:0] rings;
    logic [RadW-1:0] radius;
  } cfg_t;

  typedef struct packed {
    logic             err;
    logic             quad;
    logic [VidxW-1:0] vidx;
    logic [VidxW-1:0] below;
  } side_t;

  typedef struct packed {
    logic [TexW-1:0] tex_u;
    logic [TexW-1:0] tex_v;
  } tex_t;

  typedef struct packed {
    side_t side;
    tex_t  tex;
  } meta_t;

  // arctangent of 2^-i in phase units
  function automatic logic [PhaseW-1:0] atan_phase(input int i);
    logic [PhaseW-1:0] r;
    case (i)
      0:       r = 32'h20000000;
      1:       r = 32'h12E4051E;
      2:       r = 32'h09FB385B;
      3:       r = 32'h051111D4;
      4:       r = 32'h028B0D43;
      5:       r = 32'h0145D7E1;
      6:       r = 32'h00A2F61E;
      7:       r = 32'h00517C55;
      8:       r = 32'h0028BE53;
      9:       r = 32'h00145F2F;
      10:      r = 32'h000A2F98;
      11:      r = 32'h000517CC;
      12:      r = 32'h00028BE6;
      13:      r = 32'h000145F3;
      14:      r = 32'h0000A2F9;
      15:      r = 32'h0000517C;
      16:      r = 32'h000028BE;
      17:      r = 32'h0000145F;
      18:      r = 32'h00000A2F;
      19:      r = 32'h00000517;
      20:      r = 32'h0000028B;
      21:      r = 32'h00000145;
      22:      r = 32'h000000A2;
      23:      r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/uvs_divider.sv]
// index checks, flat indices and pipelined phase division of the grid indices
`default_nettype none

module uvs_divider #(
  parameter int INDEX_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  uvs_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [uvs_pkg::IdxW-1:0]    ring_i,
  input  logic [uvs_pkg::IdxW-1:0]    seg_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [uvs_pkg::PhaseW-1:0]  lat_ph_o,
  output logic [uvs_pkg::PhaseW-1:0]  lon_ph_o,
  output uvs_pkg::meta_t              meta_o
);
  import uvs_pkg::*;

  localparam int IW = (INDEX_BITS < IdxW) ? INDEX_BITS : IdxW;
  localparam int PW = 2 * IW + 2;
  localparam int NS = DivStages + 1;

  logic [IW-1:0] ring, seg, rings, segs;
  logic [IW-1:0] dvs [2];

  logic          v_q   [NS];
  logic          vin   [NS];
  logic          rdy   [NS+1];
  logic [IW-1:0]    rem_q [NS][2];
  logic [IW-1:0]    rem_n [NS][2];
  logic [QuotW-1:0] quo_q [NS][2];
  logic [QuotW-1:0] quo_n [NS][2];
  side_t         side_q [NS];
  side_t         side_n [NS];

  assign ring   = ring_i[IW-1:0];
  assign seg    = seg_i[IW-1:0];
  assign rings  = cfg_i.rings[IW-1:0];
  assign segs   = cfg_i.segs[IW-1:0];
  assign dvs[0] = rings;
  assign dvs[1] = segs;

  always_comb begin
    logic          err, quad, top;
    logic [PW-1:0] vfull, bfull;
    logic [IW:0]   r2;
    logic [IW-1:0] num;
    // front: range checks and flat indices
    err   = (rings == '0) || (segs == '0) || (ring > rings) || (seg > segs);
    quad  = !err && (ring < rings) && (seg < segs);
    vfull = PW'(ring) * (PW'(segs) + PW'(1)) + PW'(seg);
    bfull = vfull + PW'(segs) + PW'(1);
    side_n[0].err   = err;
    side_n[0].quad  = quad;
    side_n[0].vidx  = VidxW'(vfull);
    side_n[0].below = quad ? VidxW'(bfull) : '0;
    vin[0] = in_valid_i;
    for (int l = 0; l < 2; l++) begin
      num = (l == 0) ? ring : seg;
      // an in-range index never exceeds its count, so the top bit means a full turn
      top = (num >= dvs[l]);
      quo_n[0][l] = QuotW'(top);
      rem_n[0][l] = top ? '0 : num;
    end
    // restoring division, four quotient bits per stage
    for (int k = 1; k < NS; k++) begin
      vin[k]    = v_q[k-1];
      side_n[k] = side_q[k-1];
      for (int l = 0; l < 2; l++) begin
        rem_n[k][l] = rem_q[k-1][l];
        quo_n[k][l] = quo_q[k-1][l];
        for (int s = 0; s < DivStepsPerStage; s++) begin
          r2 = {rem_n[k][l], 1'b0};
          if (r2 >= {1'b0, dvs[l]}) begin
            rem_n[k][l] = IW'(r2 - {1'b0, dvs[l]});
            quo_n[k][l] = {quo_n[k][l][QuotW-2:0], 1'b1};
          end else begin
            rem_n[k][l] = r2[IW-1:0];
            quo_n[k][l] = {quo_n[k][l][QuotW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign rdy[NS] = out_ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) v_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= vin[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k] && vin[k]) begin
        rem_q[k]  <= rem_n[k];
        quo_q[k]  <= quo_n[k];
        side_q[k] <= side_n[k];
      end
    end
  end

  assign out_valid_o      = v_q[NS-1];
  assign lat_ph_o         = quo_q[NS-1][0][QuotW-1:1];
  assign lon_ph_o         = quo_q[NS-1][1][PhaseW-1:0];
  assign meta_o.side      = side_q[NS-1];
  assign meta_o.tex.tex_v = quo_q[NS-1][0][QuotW-1:QuotW-TexW];
  assign meta_o.tex.tex_u = TexW'(65536) - quo_q[NS-1][1][QuotW-1:QuotW-TexW];

endmodule

`default_nettype wire

[sv/uvs_cordic.sv]
// two-lane pipelined rotation cordic, one iteration per stage
`default_nettype none

module uvs_cordic #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [uvs_pkg::PhaseW-1:0]        lat_ph_i,
  input  logic [uvs_pkg::PhaseW-1:0]        lon_ph_i,
  input  uvs_pkg::meta_t                    meta_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [uvs_pkg::CordW-1:0]  sin_lat_o,
  output logic signed [uvs_pkg::CordW-1:0]  cos_lat_o,
  output logic signed [uvs_pkg::CordW-1:0]  sin_lon_o,
  output logic signed [uvs_pkg::CordW-1:0]  cos_lon_o,
  output uvs_pkg::meta_t                    meta_o
);
  import uvs_pkg::*;

  localparam int NI = (TRIG_ITERATIONS < AtanLen) ? TRIG_ITERATIONS : AtanLen;

  logic [PhaseW-1:0] ph [2];
  logic              v_q [NI];
  logic              vin [NI];
  logic              rdy [NI+1];
  logic signed [CordW-1:0] x_q [NI][2];
  logic signed [CordW-1:0] y_q [NI][2];
  logic signed [CordW-1:0] z_q [NI][2];
  logic signed [CordW-1:0] x_n [NI][2];
  logic signed [CordW-1:0] y_n [NI][2];
  logic signed [CordW-1:0] z_n [NI][2];
  logic        f_q [NI][2];
  logic        f_n [NI][2];
  meta_t       m_q [NI];
  meta_t       m_n [NI];

  assign ph[0] = lat_ph_i;
  assign ph[1] = lon_ph_i;

  always_comb begin
    logic signed [CordW-1:0] xc, yc, zc, xs, ys;
    logic [PhaseW-1:0]       a, t;
    logic                    fl;
    for (int k = 0; k < NI; k++) begin
      vin[k] = (k == 0) ? in_valid_i : v_q[k-1];
      m_n[k] = (k == 0) ? meta_i : m_q[k-1];
      for (int l = 0; l < 2; l++) begin
        if (k == 0) begin
          // fold the phase into the right half plane
          a  = ph[l];
          t  = a + 32'h4000_0000;
          fl = t[PhaseW-1];
          if (fl) a = a + 32'h8000_0000;
          xc = CORDIC_START;
          yc = '0;
          zc = CordW'(signed'(a));
        end else begin
          xc = x_q[k-1][l];
          yc = y_q[k-1][l];
          zc = z_q[k-1][l];
          fl = f_q[k-1][l];
        end
        xs = xc >>> k;
        ys = yc >>> k;
        if (!zc[CordW-1]) begin
          x_n[k][l] = xc - ys;
          y_n[k][l] = yc + xs;
          z_n[k][l] = zc - CordW'(atan_phase(k));
        end else begin
          x_n[k][l] = xc + ys;
          y_n[k][l] = yc - xs;
          z_n[k][l] = zc + CordW'(atan_phase(k));
        end
        if ((k == NI - 1) && fl) begin
          x_n[k][l] = -x_n[k][l];
          y_n[k][l] = -y_n[k][l];
        end
        f_n[k][l] = fl;
      end
    end
  end

  assign rdy[NI] = out_ready_i;
  for (genvar k = 0; k < NI; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NI; k++) v_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < NI; k++) begin
        if (rdy[k]) v_q[k] <= vin[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NI; k++) begin
      if (rdy[k] && vin[k]) begin
        x_q[k] <= x_n[k];
        y_q[k] <= y_n[k];
        z_q[k] <= z_n[k];
        f_q[k] <= f_n[k];
        m_q[k] <= m_n[k];
      end
    end
  end

  assign out_valid_o = v_q[NI-1];
  assign sin_lat_o   = y_q[NI-1][0];
  assign cos_lat_o   = x_q[NI-1][0];
  assign sin_lon_o   = y_q[NI-1][1];
  assign cos_lon_o   = x_q[NI-1][1];
  assign meta_o      = m_q[NI-1];

endmodule

`default_nettype wire

[sv/uvs_scale.sv]
// trig products, radius scaling, rounding and saturation into the output register
`default_nettype none

module uvs_scale (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [uvs_pkg::RadW-1:0]          radius_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [uvs_pkg::CordW-1:0]  sin_lat_i,
  input  logic signed [uvs_pkg::CordW-1:0]  cos_lat_i,
  input  logic signed [uvs_pkg::CordW-1:0]  sin_lon_i,
  input  logic signed [uvs_pkg::CordW-1:0]  cos_lon_i,
  input  uvs_pkg::meta_t                    meta_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [uvs_pkg::PosW-1:0]          pos_x_o,
  output logic [uvs_pkg::PosW-1:0]          pos_y_o,
  output logic [uvs_pkg::PosW-1:0]          pos_z_o,
  output logic [uvs_pkg::TexW-1:0]          tex_u_o,
  output logic [uvs_pkg::TexW-1:0]          tex_v_o,
  output logic [uvs_pkg::VidxW-1:0]         vertex_index_o,
  output logic [uvs_pkg::VidxW-1:0]         below_index_o,
  output logic                              quad_valid_o,
  output logic                              index_error_o
);
  import uvs_pkg::*;

  localparam int PPW = 2 * CordW;      // trig product
  localparam int RW  = PPW - 30;       // trig product after rounding
  localparam int QW  = RadW + 1 + RW;  // radius product
  localparam logic signed [PPW-1:0] RndP   = PPW'(1) << 29;
  localparam logic signed [QW-1:0]  RndQ   = QW'(1) << 29;
  localparam logic signed [QW-1:0]  PosMax = QW'(65535);
  localparam logic signed [QW-1:0]  PosMin = -PosMax;

  function automatic logic [PosW-1:0] round_sat(input logic signed [QW-1:0] p);
    logic signed [QW-1:0] v;
    v = (p + RndQ) >>> 30;
    if (v > PosMax) v = PosMax;
    if (v < PosMin) v = PosMin;
    return v[PosW-1:0];
  endfunction

  logic                    v1_q, v2_q, v3_q;
  logic                    rdy1, rdy2, rdy3;
  logic signed [PPW-1:0]   px_q, pz_q;
  logic signed [CordW-1:0] cl_q;
  meta_t                   m1_q, m2_q;
  logic signed [QW-1:0]    qx_q, qy_q, qz_q;
  logic signed [QW-1:0]    qx_d, qy_d, qz_d;
  logic signed [RadW:0]    rad;

  assign rad = signed'({1'b0, radius_i});

  always_comb begin
    logic signed [PPW-1:0] sx, sz;
    logic signed [RW-1:0]  tx, tz;
    sx   = (px_q + RndP) >>> 30;
    sz   = (pz_q + RndP) >>> 30;
    tx   = RW'(sx);
    tz   = RW'(sz);
    qx_d = rad * tx;
    qz_d = rad * tz;
    qy_d = rad * cl_q;
  end

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      px_q <= sin_lat_i * cos_lon_i;
      pz_q <= sin_lat_i * sin_lon_i;
      cl_q <= cos_lat_i;
      m1_q <= meta_i;
    end
    if (rdy2 && v1_q) begin
      qx_q <= qx_d;
      qy_q <= qy_d;
      qz_q <= qz_d;
      m2_q <= m1_q;
    end
    if (rdy3 && v2_q) begin
      // out-of-range items give all-zero fields
      if (m2_q.side.err) begin
        pos_x_o        <= '0;
        pos_y_o        <= '0;
        pos_z_o        <= '0;
        tex_u_o        <= '0;
        tex_v_o        <= '0;
        vertex_index_o <= '0;
        below_index_o  <= '0;
        quad_valid_o   <= 1'b0;
      end else begin
        pos_x_o        <= round_sat(qx_q);
        pos_y_o        <= round_sat(qy_q);
        pos_z_o        <= round_sat(qz_q);
        tex_u_o        <= m2_q.tex.tex_u;
        tex_v_o        <= m2_q.tex.tex_v;
        vertex_index_o <= m2_q.side.vidx;
        below_index_o  <= m2_q.side.below;
        quad_valid_o   <= m2_q.side.quad;
      end
      index_error_o <= m2_q.side.err;
    end
  end

  assign out_valid_o = v3_q;

endmodule

`default_nettype wire

[sv/uv_sphere_vertex_generator_unit.sv]
// uv sphere vertex generator: one (ring, segment) grid index in, one sphere vertex out
//
// The input channel takes a ring and segment index with valid/ready; the output
// channel gives the Q8.8 position, Q1.16 texture coordinates, the flat vertex
// index, the index one ring below, the quad flag and the index error flag.
// The user must set counts and radius through the write port only while no item
// is in flight; the block itself does not enforce this. The pipeline has a stage
// of index checks, 8 stages of phase division at four quotient bits each, one
// cordic iteration per stage, and 3 stages of products, rounding and saturation.
// Throughput is one item per clock unless the receiver stalls; every stage
// holds one item.
// Reset empties the pipeline and loads segment_count 64, ring_count 32 and a
// radius of 2.0. When the receiver stalls, the held result stays on the output
// and items behind it keep moving into empty stages, so the input is refused
// only once every stage is full.
`default_nettype none

module uv_sphere_vertex_generator_unit #(
  parameter int INDEX_BITS      = 10,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [uvs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [uvs_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [uvs_pkg::IdxW-1:0]      ring_index_i,
  input  logic [uvs_pkg::IdxW-1:0]      segment_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [uvs_pkg::PosW-1:0]      pos_x_o,
  output logic [uvs_pkg::PosW-1:0]      pos_y_o,
  output logic [uvs_pkg::PosW-1:0]      pos_z_o,
  output logic [uvs_pkg::TexW-1:0]      tex_u_o,
  output logic [uvs_pkg::TexW-1:0]      tex_v_o,
  output logic [uvs_pkg::VidxW-1:0]     vertex_index_o,
  output logic [uvs_pkg::VidxW-1:0]     below_index_o,
  output logic                          quad_valid_o,
  output logic                          index_error_o
);
  import uvs_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.segs   <= IdxW'(64);
      cfg_q.rings  <= IdxW'(32);
      cfg_q.radius <= RadW'(512);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SEGMENT_COUNT: cfg_q.segs   <= cfg_data_i[IdxW-1:0];
        CFG_RING_COUNT:    cfg_q.rings  <= cfg_data_i[IdxW-1:0];
        CFG_SPHERE_RADIUS: cfg_q.radius <= cfg_data_i[RadW-1:0];
        default: ;
      endcase
    end
  end

  logic                    div_valid, div_ready;
  logic [PhaseW-1:0]       lat_ph, lon_ph;
  meta_t                   div_meta;
  logic                    cor_valid, cor_ready;
  logic signed [CordW-1:0] sin_lat, cos_lat, sin_lon, cos_lon;
  meta_t                   cor_meta;

  uvs_divider #(
    .INDEX_BITS (INDEX_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ring_i      (ring_index_i),
    .seg_i       (segment_index_i),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .lat_ph_o    (lat_ph),
    .lon_ph_o    (lon_ph),
    .meta_o      (div_meta)
  );

  uvs_cordic #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .lat_ph_i    (lat_ph),
    .lon_ph_i    (lon_ph),
    .meta_i      (div_meta),
    .out_valid_o (cor_valid),
    .out_ready_i (cor_ready),
    .sin_lat_o   (sin_lat),
    .cos_lat_o   (cos_lat),
    .sin_lon_o   (sin_lon),
    .cos_lon_o   (cos_lon),
    .meta_o      (cor_meta)
  );

  uvs_scale u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .radius_i       (cfg_q.radius),
    .in_valid_i     (cor_valid),
    .in_ready_o     (cor_ready),
    .sin_lat_i      (sin_lat),
    .cos_lat_i      (cos_lat),
    .sin_lon_i      (sin_lon),
    .cos_lon_i      (cos_lon),
    .meta_i         (cor_meta),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o),
    .tex_u_o        (tex_u_o),
    .tex_v_o        (tex_v_o),
    .vertex_index_o (vertex_index_o),
    .below_index_o  (below_index_o),
    .quad_valid_o   (quad_valid_o),
    .index_error_o  (index_error_o)
  );

endmodule

`default_nettype wire

[sv/uvs_checker.sv]
// port-level assertions for the uv sphere vertex generator, bound to the top level
`default_nettype none

module uvs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [uvs_pkg::PosW-1:0]    pos_x_o,
  input logic [uvs_pkg::PosW-1:0]    pos_y_o,
  input logic [uvs_pkg::PosW-1:0]    pos_z_o,
  input logic [uvs_pkg::TexW-1:0]    tex_u_o,
  input logic [uvs_pkg::TexW-1:0]    tex_v_o,
  input logic [uvs_pkg::VidxW-1:0]   vertex_index_o,
  input logic [uvs_pkg::VidxW-1:0]   below_index_o,
  input logic                        quad_valid_o,
  input logic                        index_error_o
);
  import uvs_pkg::*;

  // an item with a bad index carries nothing but the error flag
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |->
      pos_x_o == '0 && pos_y_o == '0 && pos_z_o == '0 && tex_u_o == '0 &&
      tex_v_o == '0 && vertex_index_o == '0 && below_index_o == '0 && !quad_valid_o)
    else $error("error item with nonzero fields");

  a_quad_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && quad_valid_o |-> !index_error_o && tex_u_o != '0 &&
      tex_v_o != TexW'(65536))
    else $error("quad flag on an edge vertex");

  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tex_u_o <= TexW'(65536) && tex_v_o <= TexW'(65536))
    else $error("texture coordinate above one");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o) &&
      $stable(vertex_index_o) && $stable(index_error_o))
    else $error("stalled item changed");

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("valid item during reset");

endmodule

bind uv_sphere_vertex_generator_unit uvs_checker u_checker (.*);

`default_nettype wire

[tb/tb.sv]
// testbench for the uv sphere vertex generator: random and directed grid indices
module tb;
  import uvs_pkg::*;

  localparam int LatCycles = 28;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic [IdxW-1:0] ring;
    logic [IdxW-1:0] seg;
  } grid_t;

  typedef struct packed {
    logic [PosW-1:0]  px;
    logic [PosW-1:0]  py;
    logic [PosW-1:0]  pz;
    logic [TexW-1:0]  tu;
    logic [TexW-1:0]  tv;
    logic [VidxW-1:0] vidx;
    logic [VidxW-1:0] below;
    logic             quad;
    logic             err;
  } vertex_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [IdxW-1:0] ring_index_i, segment_index_i;
  logic out_valid_o, out_ready_i;
  logic [PosW-1:0] pos_x_o, pos_y_o, pos_z_o;
  logic [TexW-1:0] tex_u_o, tex_v_o;
  logic [VidxW-1:0] vertex_index_o, below_index_o;
  logic quad_valid_o, index_error_o;

  uv_sphere_vertex_generator_unit uut (.*);

  grid_t   pending_q[$];
  vertex_t vertex_q[$];
  logic [IdxW-1:0] segs_m, rings_m;
  logic [RadW-1:0] radius_m;
  int  send_idle_pct, recv_stall_pct;
  bit  hold_off;
  int  hold_cycles;
  int  errors;
  bit  in_taken;
  longint cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void cordic_sincos(logic [31:0] phase, output longint s,
                                        output longint c);
    logic [31:0] a;
    bit flip;
    longint x, y, z, xs, ys;
    a = phase;
    x = 64'h26DD3B6A;
    y = 0;
    flip = 1'b0;
    if (((a + 32'h40000000) & 32'h80000000) != 0) begin
      a = a + 32'h80000000;
      flip = 1'b1;
    end
    z = longint'(signed'(a));
    for (int i = 0; i < 16; i++) begin
      xs = sra(x, i);
      ys = sra(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_phase(i));
      end else begin
        x += ys; y -= xs; z += longint'(atan_phase(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic longint rnd30(longint p);
    return sra(p + (64'sd1 <<< 29), 30);
  endfunction

  function automatic logic [PosW-1:0] sat_pos(longint v);
    if (v > 65535) v = 65535;
    if (v < -65535) v = -65535;
    return v[PosW-1:0];
  endfunction

  function automatic vertex_t vertex_of(grid_t g);
    vertex_t v;
    longint unsigned ring, seg, rings, segs, vid;
    longint sl, cl, so, co, r;
    logic [31:0] lat, lon;
    v = '0;
    ring = g.ring; seg = g.seg; rings = rings_m; segs = segs_m;
    r = radius_m;
    if (rings == 0 || segs == 0 || ring > rings || seg > segs) begin
      v.err = 1'b1;
      return v;
    end
    lat = 32'((ring << 31) / rings);
    lon = 32'((seg << 32) / segs);
    cordic_sincos(lat, sl, cl);
    cordic_sincos(lon, so, co);
    v.px = sat_pos(rnd30(r * rnd30(sl * co)));
    v.py = sat_pos(rnd30(r * cl));
    v.pz = sat_pos(rnd30(r * rnd30(sl * so)));
    v.tu = 17'(65536 - ((seg << 16) / segs));
    v.tv = 17'((ring << 16) / rings);
    vid = ring * (segs + 1) + seg;
    v.vidx = vid[VidxW-1:0];
    if (ring < rings && seg < segs) begin
      v.below = 20'(vid + segs + 1);
      v.quad = 1'b1;
    end
    return v;
  endfunction

  function automatic void add_item(logic [IdxW-1:0] ring, logic [IdxW-1:0] seg);
    grid_t g;
    g.ring = ring;
    g.seg = seg;
    pending_q.insert(pending_q.size(), g);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          grid_t g;
          g = pending_q.pop_front();
          vertex_q.insert(vertex_q.size(), vertex_of(g));
          ring_index_i <= g.ring;
          segment_index_i <= g.seg;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: note input acceptance and compare each accepted result
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      vertex_t w;
      if (vertex_q.size() == 0) begin
        report_mismatch("unexpected item", vertex_index_o, 0);
      end else begin
        w = vertex_q.pop_front();
        if (pos_x_o !== w.px) report_mismatch("pos_x", pos_x_o, w.px);
        if (pos_y_o !== w.py) report_mismatch("pos_y", pos_y_o, w.py);
        if (pos_z_o !== w.pz) report_mismatch("pos_z", pos_z_o, w.pz);
        if (tex_u_o !== w.tu) report_mismatch("tex_u", tex_u_o, w.tu);
        if (tex_v_o !== w.tv) report_mismatch("tex_v", tex_v_o, w.tv);
        if (vertex_index_o !== w.vidx) report_mismatch("vertex_index", vertex_index_o, w.vidx);
        if (below_index_o !== w.below) report_mismatch("below_index", below_index_o, w.below);
        if (quad_valid_o !== w.quad) report_mismatch("quad_valid", quad_valid_o, w.quad);
        if (index_error_o !== w.err) report_mismatch("index_error", index_error_o, w.err);
      end
    end
  end

  // long receiver hold-off so the pipeline fills and refuses input
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      if (hold_cycles == 1) hold_off <= 1'b0;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SEGMENT_COUNT: segs_m = val[IdxW-1:0];
      CFG_RING_COUNT:    rings_m = val[IdxW-1:0];
      default:           radius_m = val;
    endcase
  endtask

  task automatic set_sphere(int segs, int rings, int rad);
    write_reg(CFG_SEGMENT_COUNT, CfgW'(segs));
    write_reg(CFG_RING_COUNT, CfgW'(rings));
    write_reg(CFG_SPHERE_RADIUS, CfgW'(rad));
  endtask

  task automatic drain;
    while (pending_q.size() != 0 || vertex_q.size() != 0 || in_valid_i) @(posedge clk_i);
    repeat (LatCycles + 4) @(posedge clk_i);
  endtask

  // mostly in-range indices, some at or just past the counts, some anywhere
  task automatic add_random(int n);
    grid_t g;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: begin
          g.ring = IdxW'($urandom);
          g.seg = IdxW'($urandom);
        end
        1: begin
          g.ring = IdxW'(rings_m + $urandom_range(2));
          g.seg = IdxW'(segs_m + $urandom_range(2));
        end
        default: begin
          g.ring = IdxW'($urandom_range(rings_m));
          g.seg = IdxW'($urandom_range(segs_m));
        end
      endcase
      pending_q.insert(pending_q.size(), g);
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    in_taken = 1'b0;
    hold_off = 1'b0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    segs_m = 64; rings_m = 32; radius_m = 512;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_SEGMENT_COUNT; cfg_data_i = '0;
    in_valid_i = 1'b0; ring_index_i = '0; segment_index_i = '0;
    out_ready_i = 1'b0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings, poles, seam, bounds, past range
    add_item(0, 0);
    add_item(32, 64);
    add_item(16, 16);
    add_item(16, 32);
    add_item(8, 48);
    add_item(31, 63);
    add_item(33, 0);
    add_item(0, 65);
    add_item(1023, 1023);
    drain();

    set_sphere(1023, 1023, 65535);
    add_item(1023, 1023);
    add_item(511, 255);
    add_item(1022, 1022);
    add_item(341, 682);
    add_random(20);
    drain();

    set_sphere(3, 2, 0);
    add_item(1, 1);
    add_item(2, 3);
    add_random(6);
    drain();

    // zero counts and counts below their stated range
    set_sphere(0, 5, 256);
    add_item(1, 0);
    drain();
    set_sphere(1, 1, 1000);
    add_item(1, 1);
    add_item(0, 0);
    drain();
    set_sphere(2, 0, 1000);
    add_item(0, 1);
    drain();

    // random phases with idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      set_sphere($urandom_range(3, 1023), $urandom_range(2, 1023), $urandom_range(65535));
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 77 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 77 : (ph % 4 == 3) ? 17 : 0;
      if (ph % 4 == 3) send_idle_pct = 17;
      if (ph == 4) begin
        hold_off = 1'b1;
        hold_cycles = 200;
      end
      add_random(50);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
